/* rtl/fixed_latency_channel_queue_macros.svh */
// Assertion macros for the channel queue. Each check runs on the rising edge of clk.
`ifndef FIXED_LATENCY_CHANNEL_QUEUE_MACROS_SVH
`define FIXED_LATENCY_CHANNEL_QUEUE_MACROS_SVH

`ifndef SYNTH
// Checks that are switched off while rst is high.
`define FLCQ_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checks that also hold while rst is high.
`define FLCQ_CHECK_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FLCQ_CHECK(name, prop, msg)
`define FLCQ_CHECK_RST(name, prop, msg)
`endif

`endif

/* rtl/flcq_pkg.sv */
package flcq_pkg;

  localparam int KIND_W     = 2;
  localparam int CH_FIELD_W = 4;
  localparam int TAG_W      = 16;
  localparam int TIME_W     = 48;
  localparam int LAT_W      = 16;
  localparam int ACT_W      = 5;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DROP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LATENCY = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE  = 4'd1;

  localparam logic [LAT_W-1:0] LATENCY_RESET = 16'd100;
  localparam logic [ACT_W-1:0] ACTIVE_RESET  = 5'd16;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [CH_FIELD_W-1:0] channel;
    logic [TAG_W-1:0]      tag;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    resp_tag;
    logic                resp_empty;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_t;

endpackage

/* rtl/flcq_chan_if.sv */
interface flcq_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/fixed_latency_channel_queue.sv */
// Channel  Direction  Word
// req      in         kind, channel, tag
// rsp      out        status, resp_tag, resp_empty
// cfg      in         index, value (0 latency, 1 active_channels)
//
// A tick, once taken, keeps the block busy for one wait-store read per channel, up to
// min(active_channels, CHANNELS), overlapped with the due check of the channel before
// it in the shared 48-bit adder, then the last check, a settling step, the cycle count
// step and the result. A push that reaches the stores passes the add and compare states,
// a pop the read and data states; a dropped push, an empty pop and the rest skip them.
// Reset is synchronous and clears the pointers, counts and times; the stores need no clear.
// A waiting result does not block the next word; a stalled rsp holds the block in its
// final state until the output register frees.
`include "fixed_latency_channel_queue_macros.svh"

module fixed_latency_channel_queue
  import flcq_pkg::*;
#(
  parameter int CHANNELS   = 16,
  parameter int WAIT_DEPTH = 16,
  parameter int RESP_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  flcq_chan_if.sink    req,
  flcq_chan_if.source  rsp,
  flcq_chan_if.sink    cfg
);

  localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WI           = $clog2(WAIT_DEPTH);
  localparam int RI           = $clog2(RESP_DEPTH);
  localparam int WAIT_ENTRIES = 1 << (CH_W + WI);
  localparam int RESP_ENTRIES = 1 << (CH_W + RI);
  localparam int WAIT_ENTRY_W = TIME_W + TAG_W;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_TICK     = 8'b0000_0010,
    ST_TICK_INC = 8'b0000_0100,
    ST_PUSH_ADD = 8'b0000_1000,
    ST_PUSH_CMP = 8'b0001_0000,
    ST_POP_RD   = 8'b0010_0000,
    ST_POP_DATA = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [LAT_W-1:0]  latency;
  logic [ACT_W-1:0]  active_channels;
  logic [TIME_W-1:0] cycle_count;
  logic [TIME_W-1:0] last_finish;
  logic [TIME_W-1:0] tmp;
  logic [CH_W-1:0]   ch;
  logic [TAG_W-1:0]  tag;
  rsp_t              res, res_next;

  logic [WI-1:0] wait_head [CHANNELS];
  logic [WI:0]   wait_fill [CHANNELS];
  logic [RI-1:0] resp_head [CHANNELS];
  logic [RI:0]   resp_fill [CHANNELS];

  logic [WAIT_ENTRY_W-1:0] wait_mem [WAIT_ENTRIES];
  logic [TAG_W-1:0]        resp_mem [RESP_ENTRIES];
  logic [WAIT_ENTRY_W-1:0] wait_rdata;
  logic [TAG_W-1:0]        resp_rdata;

  logic                    wmem_we;
  logic [CH_W+WI-1:0]      wmem_waddr, wmem_raddr;
  logic [WAIT_ENTRY_W-1:0] wmem_wdata;
  logic                    rmem_we;
  logic [CH_W+RI-1:0]      rmem_waddr, rmem_raddr;

  // Tick walk: vis is the next channel to read, pend marks a read whose due check is open.
  logic [ACT_W-1:0] vis;
  logic [ACT_W-1:0] tick_cnt;
  logic [CH_W-1:0]  vis_ch;
  logic [CH_W-1:0]  pend_ch;
  logic             pend;
  logic             visit_more;
  logic             tick_move;

  logic [CH_W-1:0] cur_ch;
  logic            ch_ok;
  logic [WI:0]     wsum;
  logic [WI-1:0]   wwr_idx;
  logic [RI:0]     rsum;
  logic [RI-1:0]   rwr_idx;

  logic [TIME_W-1:0] alu_a, alu_b, alu_result;
  logic              alu_sub, alu_carry;
  logic              out_free;

  flcq_time_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .result (alu_result),
    .carry  (alu_carry)
  );

  assign req.ready  = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;
  assign out_free   = !rsp.valid || rsp.ready;

  assign cur_ch     = CH_W'(req.data.channel);
  assign ch_ok      = (32'(req.data.channel) < CHANNELS);
  assign tick_cnt   = (32'(active_channels) > CHANNELS) ? ACT_W'(CHANNELS) : active_channels;
  assign vis_ch     = CH_W'(vis);
  assign visit_more = (vis < tick_cnt);

  // Ring positions for the tail writes, wrapped at the queue depth.
  assign wsum    = {1'b0, wait_head[ch]} + wait_fill[ch];
  assign wwr_idx = (wsum >= (WI + 1)'(WAIT_DEPTH)) ? WI'(wsum - (WI + 1)'(WAIT_DEPTH))
                                                   : WI'(wsum);
  assign rsum    = {1'b0, resp_head[pend_ch]} + resp_fill[pend_ch];
  assign rwr_idx = (rsum >= (RI + 1)'(RESP_DEPTH)) ? RI'(rsum - (RI + 1)'(RESP_DEPTH))
                                                   : RI'(rsum);

  always_comb begin
    state_next = state;
    res_next   = res;
    alu_a      = cycle_count;
    alu_b      = TIME_W'(latency);
    alu_sub    = 1'b0;
    wmem_we    = 1'b0;
    wmem_waddr = {ch, wwr_idx};
    wmem_wdata = {(alu_carry ? tmp : last_finish), tag};
    wmem_raddr = {vis_ch, wait_head[vis_ch]};
    rmem_we    = 1'b0;
    rmem_waddr = {pend_ch, rwr_idx};
    rmem_raddr = {ch, resp_head[ch]};
    tick_move  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          case (req.data.kind)
            KIND_TICK: state_next = ST_TICK;
            KIND_PUSH: begin
              if (!ch_ok) begin
                res_next   = '{STATUS_DROP, '0, 1'b1};
                state_next = ST_DONE;
              end else if (wait_fill[cur_ch] == (WI + 1)'(WAIT_DEPTH)) begin
                res_next   = '{STATUS_DROP, '0, (resp_fill[cur_ch] == '0)};
                state_next = ST_DONE;
              end else begin
                state_next = ST_PUSH_ADD;
              end
            end
            KIND_POP: begin
              if (!ch_ok || resp_fill[cur_ch] == '0) begin
                res_next   = '{STATUS_EMPTY, '0, 1'b1};
                state_next = ST_DONE;
              end else begin
                state_next = ST_POP_RD;
              end
            end
            default: begin
              res_next   = '{STATUS_OK, '0, 1'b0};
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_TICK: begin
        // The head is due when the current cycle is not below its finish time.
        alu_a   = cycle_count;
        alu_b   = wait_rdata[WAIT_ENTRY_W-1:TAG_W];
        alu_sub = 1'b1;
        if (pend && alu_carry) begin
          tick_move = 1'b1;
          rmem_we   = 1'b1;
        end
        if (!visit_more && !pend) begin
          state_next = ST_TICK_INC;
        end
      end
      ST_TICK_INC: begin
        alu_b      = TIME_W'(1);
        res_next   = '{STATUS_OK, '0, 1'b0};
        state_next = ST_DONE;
      end
      ST_PUSH_ADD: state_next = ST_PUSH_CMP;
      ST_PUSH_CMP: begin
        alu_a      = tmp;
        alu_b      = last_finish;
        alu_sub    = 1'b1;
        wmem_we    = 1'b1;
        res_next   = '{STATUS_OK, '0, (resp_fill[ch] == '0)};
        state_next = ST_DONE;
      end
      ST_POP_RD: state_next = ST_POP_DATA;
      ST_POP_DATA: begin
        res_next   = '{STATUS_OK, resp_rdata, (resp_fill[ch] == (RI + 1)'(1))};
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wmem_we) begin
      wait_mem[wmem_waddr] <= wmem_wdata;
    end
    wait_rdata <= wait_mem[wmem_raddr];
    if (rmem_we) begin
      resp_mem[rmem_waddr] <= wait_rdata[TAG_W-1:0];
    end
    resp_rdata <= resp_mem[rmem_raddr];
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (state == ST_IDLE) begin
      ch  <= cur_ch;
      tag <= req.data.tag;
    end
    if (state == ST_PUSH_ADD) begin
      tmp <= alu_result;
    end
    if (state == ST_TICK && visit_more) begin
      pend_ch <= vis_ch;
    end
    if (state == ST_DONE && out_free) begin
      rsp.data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      latency         <= LATENCY_RESET;
      active_channels <= ACTIVE_RESET;
      cycle_count     <= '0;
      last_finish     <= '0;
      vis             <= '0;
      pend            <= 1'b0;
      rsp.valid       <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        wait_head[i] <= '0;
        wait_fill[i] <= '0;
        resp_head[i] <= '0;
        resp_fill[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        unique case (cfg.data.index)
          REG_LATENCY: latency <= cfg.data.value;
          REG_ACTIVE:  active_channels <= cfg.data.value[ACT_W-1:0];
          default: ;
        endcase
      end
      if (state == ST_DONE && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          vis  <= '0;
          pend <= 1'b0;
        end
        ST_TICK: begin
          if (visit_more) begin
            pend <= (wait_fill[vis_ch] != '0) &&
                    (resp_fill[vis_ch] != (RI + 1)'(RESP_DEPTH));
            vis  <= vis + 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (tick_move) begin
            wait_head[pend_ch] <= (wait_head[pend_ch] == WI'(WAIT_DEPTH - 1))
                                  ? '0 : wait_head[pend_ch] + 1'b1;
            wait_fill[pend_ch] <= wait_fill[pend_ch] - 1'b1;
            resp_fill[pend_ch] <= resp_fill[pend_ch] + 1'b1;
          end
        end
        ST_TICK_INC: cycle_count <= alu_result;
        ST_PUSH_CMP: begin
          last_finish  <= alu_carry ? tmp : last_finish;
          wait_fill[ch] <= wait_fill[ch] + 1'b1;
        end
        ST_POP_DATA: begin
          resp_head[ch] <= (resp_head[ch] == RI'(RESP_DEPTH - 1)) ? '0 : resp_head[ch] + 1'b1;
          resp_fill[ch] <= resp_fill[ch] - 1'b1;
        end
        ST_PUSH_ADD, ST_POP_RD, ST_DONE: ;
        default: ;
      endcase
    end
  end

  `FLCQ_CHECK_RST(a_reset_idle,
    $past(rst) |-> (state == ST_IDLE && !rsp.valid && !pend),
    "reset did not leave the block idle")
  `FLCQ_CHECK(a_rsp_from_done,
    $rose(rsp.valid) |-> $past(state == ST_DONE),
    "result word raised outside the final state")
  `FLCQ_CHECK(a_accept_leaves_idle,
    (req.valid && req.ready) |=> (state != ST_IDLE),
    "accepted word did not start the sequencer")
  `FLCQ_CHECK(a_pend_in_tick,
    pend |-> (state == ST_TICK),
    "open due check outside a tick walk")

endmodule

/* rtl/flcq_time_alu.sv */
module flcq_time_alu
  import flcq_pkg::*;
(
  input  logic [TIME_W-1:0] a,
  input  logic [TIME_W-1:0] b,
  input  logic              sub,
  output logic [TIME_W-1:0] result,
  output logic              carry
);

  logic [TIME_W-1:0] b_op;

  // In subtract mode the carry out is set when a is not below b.
  assign b_op = sub ? ~b : b;
  assign {carry, result} = {1'b0, a} + {1'b0, b_op} + (TIME_W + 1)'(sub);

endmodule
